[rtl/cerr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_pkg
// Shared types and fixed widths of the channel energy rank reorder block.
// ---------------------------------------------------------------------------
package cerr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SQ_W      = 2 * SAMPLE_W - 1;
  localparam int RANK_SLOTS = 4;
  localparam int SLOT_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int RANKING_W = RANK_SLOTS * SLOT_IDX_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  typedef logic [RANK_SLOTS-1:0][SLOT_IDX_W-1:0] order_t;

  typedef struct packed {
    logic load;
    logic acc_en;
    logic clr;
  } lane_ctrl_t;

endpackage

[rtl/cerr_lane.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_lane
// One channel lane: squares the sample parts, then adds them to the
// channel's running window energy.
// ---------------------------------------------------------------------------
module cerr_lane #(
  parameter int ACC_W = 38
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cerr_pkg::lane_ctrl_t ctrl,
  input  cerr_pkg::cplx_t      smp,
  output logic [ACC_W-1:0]     energy
);

  logic [2*cerr_pkg::SAMPLE_W-1:0] prod_re;
  logic [2*cerr_pkg::SAMPLE_W-1:0] prod_im;
  logic [cerr_pkg::SQ_W-1:0]       sq_re_r;
  logic [cerr_pkg::SQ_W-1:0]       sq_im_r;
  logic [ACC_W-1:0]                acc_r;
  logic [ACC_W-1:0]                acc_nxt;

  assign prod_re = smp.re * smp.re;
  assign prod_im = smp.im * smp.im;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sq_re_r <= prod_re[cerr_pkg::SQ_W-1:0];
      sq_im_r <= prod_im[cerr_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    priority if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.acc_en) begin
      acc_nxt = acc_r + ACC_W'(sq_re_r) + ACC_W'(sq_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign energy = acc_r;

endmodule

[rtl/cerr_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_store
// Window buffer: one row of all lane samples per item, one write port and
// one registered read port.
// ---------------------------------------------------------------------------
module cerr_store #(
  parameter int DEPTH  = 64,
  parameter int LANES  = 4,
  parameter int ADDR_W = 6
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  cerr_pkg::cplx_t [LANES-1:0]       wr_data,
  input  logic                              rd_en,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output cerr_pkg::cplx_t [LANES-1:0]       rd_data
);

  cerr_pkg::cplx_t [LANES-1:0] mem [DEPTH];
  cerr_pkg::cplx_t [LANES-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/cerr_rank.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_rank
// Comparison rank: orders lane energies, descending, lower channel first on
// a tie, and gives the channel index held by each rank.
// ---------------------------------------------------------------------------
module cerr_rank #(
  parameter int LANES = 4,
  parameter int ACC_W = 38
) (
  input  logic [ACC_W-1:0]  energy [LANES],
  output cerr_pkg::order_t  order
);

  always_comb begin
    logic [cerr_pkg::SLOT_IDX_W-1:0] pos;
    order = '0;
    for (int c = 0; c < LANES; c++) begin
      pos = '0;
      for (int d = 0; d < LANES; d++) begin
        if ((energy[d] > energy[c]) || ((energy[d] == energy[c]) && (d < c))) begin
          pos = pos + cerr_pkg::SLOT_IDX_W'(1);
        end
      end
      order[pos] = cerr_pkg::SLOT_IDX_W'(c);
    end
  end

endmodule

[rtl/channel_energy_rank_reorder_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// channel_energy_rank_reorder_core
// Buffers a window of four-channel complex samples, ranks the channels by
// window energy and replays the window with the channels in rank order.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// while the lanes add the item's energy, so no new item is taken until the
// lanes are done with the last one. On the item that completes a window,
// busy stays high through the ranking state and then the read state of the
// window buffer, which reads one row for each item in the window; the first
// result passes the lane accumulators, the ranking register and the buffer's
// read register in turn, and the rest follow one per cycle, each shown for a
// single cycle with out_strobe, the last with out_window_end. Results cannot
// be held off; the buffer's single read port replays one row per cycle.
// ---------------------------------------------------------------------------
module channel_energy_rank_reorder_core #(
  parameter int MAX_WINDOW   = 64,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          in_ch0_re,
  input  logic signed [15:0]          in_ch0_im,
  input  logic signed [15:0]          in_ch1_re,
  input  logic signed [15:0]          in_ch1_im,
  input  logic signed [15:0]          in_ch2_re,
  input  logic signed [15:0]          in_ch2_im,
  input  logic signed [15:0]          in_ch3_re,
  input  logic signed [15:0]          in_ch3_im,
  output logic                        out_strobe,
  output logic signed [15:0]          out_rank0_re,
  output logic signed [15:0]          out_rank0_im,
  output logic signed [15:0]          out_rank1_re,
  output logic signed [15:0]          out_rank1_im,
  output logic signed [15:0]          out_rank2_re,
  output logic signed [15:0]          out_rank2_im,
  output logic signed [15:0]          out_rank3_re,
  output logic signed [15:0]          out_rank3_im,
  output logic [7:0]                  out_ranking,
  output logic                        out_window_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [6:0]                  cfg_window_len
);

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W  = (FILL_W > cerr_pkg::CFG_W) ? FILL_W : cerr_pkg::CFG_W;
  localparam int ACC_W  = 2 * cerr_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int CH_W   = $clog2(NUM_CHANNELS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_RANK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                        state_r, state_nxt;
  logic [FILL_W-1:0]                 fill_r, fill_nxt;
  logic [FILL_W-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [cerr_pkg::CFG_W-1:0]        win_len_r;
  cerr_pkg::order_t                  order_r, order_nxt;
  logic                              rd_vld_r, rd_vld_nxt;
  logic                              rd_last_r, rd_last_nxt;

  logic                              accept;
  logic                              rd_en;
  logic                              last_rd;
  logic                              win_done;
  logic [CMP_W-1:0]                  win_ext;
  logic [CMP_W-1:0]                  eff_len;
  cerr_pkg::lane_ctrl_t              lane_ctrl;
  cerr_pkg::cplx_t [3:0]             in_smp;
  cerr_pkg::cplx_t [NUM_CHANNELS-1:0] wr_row;
  cerr_pkg::cplx_t [NUM_CHANNELS-1:0] rd_row;
  logic [ACC_W-1:0]                  energy [NUM_CHANNELS];
  cerr_pkg::order_t                  order_c;
  cerr_pkg::cplx_t [3:0]             slot;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= cerr_pkg::CFG_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      win_len_r <= cfg_window_len;
    end
  end

  assign in_smp[0] = '{re: in_ch0_re, im: in_ch0_im};
  assign in_smp[1] = '{re: in_ch1_re, im: in_ch1_im};
  assign in_smp[2] = '{re: in_ch2_re, im: in_ch2_im};
  assign in_smp[3] = '{re: in_ch3_re, im: in_ch3_im};
  assign wr_row    = in_smp[NUM_CHANNELS-1:0];

  // zero acts as one, anything above the buffer depth saturates
  assign win_ext = CMP_W'(win_len_r);
  always_comb begin
    priority if (win_ext == '0) begin
      eff_len = CMP_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      eff_len = CMP_W'(MAX_WINDOW);
    end else begin
      eff_len = win_ext;
    end
  end
  assign win_done = (CMP_W'(fill_r) >= eff_len);

  assign last_rd = (FILL_W'(rd_ptr_r + FILL_W'(1)) == fill_r);
  assign rd_en   = (state_r == S_EMIT);

  assign lane_ctrl.load   = accept;
  assign lane_ctrl.acc_en = (state_r == S_ACC);
  assign lane_ctrl.clr    = rd_en && last_rd;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    cerr_lane #(
      .ACC_W (ACC_W)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (lane_ctrl),
      .smp    (in_smp[g]),
      .energy (energy[g])
    );
  end

  cerr_store #(
    .DEPTH  (MAX_WINDOW),
    .LANES  (NUM_CHANNELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r[ADDR_W-1:0]),
    .rd_data (rd_row)
  );

  cerr_rank #(
    .LANES (NUM_CHANNELS),
    .ACC_W (ACC_W)
  ) u_rank (
    .energy (energy),
    .order  (order_c)
  );

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    rd_ptr_nxt  = rd_ptr_r;
    order_nxt   = order_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          fill_nxt  = FILL_W'(fill_r + FILL_W'(1));
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = win_done ? S_RANK : S_IDLE;
      end
      S_RANK: begin
        order_nxt  = order_c;
        rd_ptr_nxt = '0;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        rd_vld_nxt  = 1'b1;
        rd_last_nxt = last_rd;
        rd_ptr_nxt  = FILL_W'(rd_ptr_r + FILL_W'(1));
        if (last_rd) begin
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      rd_ptr_r  <= '0;
      order_r   <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      order_r   <= order_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

  always_comb begin
    slot = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      slot[k] = rd_row[order_r[k][CH_W-1:0]];
    end
  end

  assign out_strobe     = rd_vld_r;
  assign out_window_end = rd_vld_r && rd_last_r;
  assign out_ranking    = order_r;
  assign out_rank0_re   = slot[0].re;
  assign out_rank0_im   = slot[0].im;
  assign out_rank1_re   = slot[1].re;
  assign out_rank1_im   = slot[1].im;
  assign out_rank2_re   = slot[2].re;
  assign out_rank2_im   = slot[2].im;
  assign out_rank3_re   = slot[3].re;
  assign out_rank3_im   = slot[3].im;

endmodule

[rtl/cerr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_checker
// Port-level checks of the channel energy rank reorder block.
// ---------------------------------------------------------------------------
module cerr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_window_end,
  input logic [7:0] out_ranking
);

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted request");

  a_end_has_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_window_end |-> out_strobe)
    else $error("window end flagged without a result");

  a_window_contiguous : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_window_end |=> out_strobe)
    else $error("gap inside a window's results");

  a_ranking_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_window_end |=> $stable(out_ranking))
    else $error("ranking changed inside a window");

  a_no_accept_mid_window : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_window_end |-> busy)
    else $error("block idle while a window is still being replayed");

endmodule

bind channel_energy_rank_reorder_core cerr_checker u_cerr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_window_end (out_window_end),
  .out_ranking    (out_ranking)
);

[verif/cerr_rank_board_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cerr_rank_board_pkg
// Scoreboard for the channel energy rank reorder core: keeps its own copy of
// the window buffer, the per-channel energy sums and the window length, ranks
// each completed window and queues the reordered rows that the core must
// replay, then checks every replayed row field by field in arrival order.
// ---------------------------------------------------------------------------
package cerr_rank_board_pkg;

  import cerr_pkg::*;

  localparam int WINDOW_CAP  = 64;
  localparam int REPORT_CAP  = 10;

  typedef cplx_t [RANK_SLOTS-1:0] lane_set_t;

  typedef struct packed {
    lane_set_t lanes;
    order_t    ranking;
    logic      window_end;
  } ranked_row_t;

  class rank_reorder_board;
    lane_set_t        window_rows [WINDOW_CAP];
    longint           energy [RANK_SLOTS];
    int               fill;
    logic [CFG_W-1:0] window_len;
    ranked_row_t      expected_rows [$];
    int               errors;
    int               rows_checked;
    int               windows_closed;

    function new();
      foreach (energy[c]) energy[c] = 0;
      fill           = 0;
      window_len     = 7'd64;
      errors         = 0;
      rows_checked   = 0;
      windows_closed = 0;
    endfunction

    function void set_window_len(logic [CFG_W-1:0] value);
      window_len = value;
    endfunction

    function int window_target();
      int n;
      n = int'(window_len);
      if (n == 0) n = 1;
      if (n > WINDOW_CAP) n = WINDOW_CAP;
      return n;
    endfunction

    function void note_request(lane_set_t item);
      longint      re_v;
      longint      im_v;
      order_t      order;
      int          pos;
      ranked_row_t row;
      if (fill < WINDOW_CAP) begin
        window_rows[fill] = item;
        for (int c = 0; c < RANK_SLOTS; c++) begin
          re_v = longint'($signed(item[c].re));
          im_v = longint'($signed(item[c].im));
          energy[c] += re_v * re_v + im_v * im_v;
        end
        fill++;
      end
      if (fill < window_target()) return;
      // rank = number of channels that beat this one; ties go to the lower index
      order = '0;
      for (int c = 0; c < RANK_SLOTS; c++) begin
        pos = 0;
        for (int d = 0; d < RANK_SLOTS; d++) begin
          if (energy[d] > energy[c] || (energy[d] == energy[c] && d < c)) pos++;
        end
        order[pos] = SLOT_IDX_W'(c);
      end
      for (int k = 0; k < fill; k++) begin
        for (int d = 0; d < RANK_SLOTS; d++) row.lanes[d] = window_rows[k][order[d]];
        row.ranking    = order;
        row.window_end = (k == fill - 1);
        expected_rows.push_back(row);
      end
      foreach (energy[c]) energy[c] = 0;
      fill = 0;
      windows_closed++;
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch on %s (row %0d): expected %0d, got %0d",
                 field, rows_checked, want, got);
    endfunction

    function void check_result(ranked_row_t got);
      ranked_row_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("row arrived with none expected: ranking %0h end %0b",
                   got.ranking, got.window_end);
        return;
      end
      want = expected_rows.pop_front();
      for (int d = 0; d < RANK_SLOTS; d++) begin
        if (got.lanes[d].re !== want.lanes[d].re)
          report($sformatf("rank%0d_re", d), longint'($signed(want.lanes[d].re)),
                 longint'($signed(got.lanes[d].re)));
        if (got.lanes[d].im !== want.lanes[d].im)
          report($sformatf("rank%0d_im", d), longint'($signed(want.lanes[d].im)),
                 longint'($signed(got.lanes[d].im)));
      end
      if (got.ranking !== want.ranking)
        report("ranking", longint'(want.ranking), longint'(got.ranking));
      if (got.window_end !== want.window_end)
        report("window_end", longint'(want.window_end), longint'(got.window_end));
      rows_checked++;
    endfunction
  endclass

endpackage

[verif/channel_energy_rank_reorder_core_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// channel_energy_rank_reorder_core_test
// Drives four-channel sample requests in random bursts under a range of
// window lengths, including zero, the maximum, saturating values and a
// mid-window shortening, and checks every replayed row against a scoreboard.
// ---------------------------------------------------------------------------
module channel_energy_rank_reorder_core_test;

  import cerr_pkg::*;
  import cerr_rank_board_pkg::*;

  localparam int ITEM_GOAL     = 260;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  typedef enum int {MIX_FULL, MIX_SCALED, MIX_TWINS, MIX_SILENT} mix_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  lane_set_t        in_item;
  logic             out_strobe;
  sample_t          out_rank0_re, out_rank0_im, out_rank1_re, out_rank1_im;
  sample_t          out_rank2_re, out_rank2_im, out_rank3_re, out_rank3_im;
  logic [7:0]       out_ranking;
  logic             out_window_end;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_window_len;

  rank_reorder_board board = new();
  int                burst_left = 0;
  int                items_sent = 0;
  int                cfg_writes = 0;
  int                quiet      = 0;
  int                lane_shift [RANK_SLOTS];

  channel_energy_rank_reorder_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_ch0_re      (in_item[0].re),
    .in_ch0_im      (in_item[0].im),
    .in_ch1_re      (in_item[1].re),
    .in_ch1_im      (in_item[1].im),
    .in_ch2_re      (in_item[2].re),
    .in_ch2_im      (in_item[2].im),
    .in_ch3_re      (in_item[3].re),
    .in_ch3_im      (in_item[3].im),
    .out_strobe     (out_strobe),
    .out_rank0_re   (out_rank0_re),
    .out_rank0_im   (out_rank0_im),
    .out_rank1_re   (out_rank1_re),
    .out_rank1_im   (out_rank1_im),
    .out_rank2_re   (out_rank2_re),
    .out_rank2_im   (out_rank2_im),
    .out_rank3_re   (out_rank3_re),
    .out_rank3_im   (out_rank3_im),
    .out_ranking    (out_ranking),
    .out_window_end (out_window_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_len (cfg_window_len)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    ranked_row_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_window_len(cfg_window_len);
      if (out_strobe) begin
        got.lanes[0].re = out_rank0_re;
        got.lanes[0].im = out_rank0_im;
        got.lanes[1].re = out_rank1_re;
        got.lanes[1].im = out_rank1_im;
        got.lanes[2].re = out_rank2_re;
        got.lanes[2].im = out_rank2_im;
        got.lanes[3].re = out_rank3_re;
        got.lanes[3].im = out_rank3_im;
        got.ranking     = out_ranking;
        got.window_end  = out_window_end;
        board.check_result(got);
      end
      if (start && !busy) board.note_request(in_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic lane_set_t mk(sample_t r0, sample_t i0, sample_t r1, sample_t i1,
                                   sample_t r2, sample_t i2, sample_t r3, sample_t i3);
    lane_set_t item;
    item[0].re = r0; item[0].im = i0;
    item[1].re = r1; item[1].im = i1;
    item[2].re = r2; item[2].im = i2;
    item[3].re = r3; item[3].im = i3;
    return item;
  endfunction

  function automatic sample_t rand_sample(int shift);
    sample_t v;
    case ($urandom_range(0, 7))
      0: v = sample_t'(-32768);
      1: v = sample_t'(32767);
      2: v = sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: v = sample_t'($urandom);
    endcase
    return v >>> shift;
  endfunction

  function automatic lane_set_t rand_item(mix_t mix);
    lane_set_t item;
    for (int c = 0; c < RANK_SLOTS; c++) begin
      item[c].re = rand_sample(mix == MIX_SCALED ? lane_shift[c] : 0);
      item[c].im = rand_sample(mix == MIX_SCALED ? lane_shift[c] : 0);
    end
    case (mix)
      MIX_TWINS: begin
        item[1] = item[0];
        item[3] = item[2];
      end
      MIX_SILENT: item[lane_shift[0] % RANK_SLOTS] = '0;
      default: ;
    endcase
    return item;
  endfunction

  task automatic send_item(lane_set_t item);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.expected_rows.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_window_len(logic [CFG_W-1:0] value);
    wait_drain();
    cfg_valid      <= 1'b1;
    cfg_window_len <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin : stimulus
    int   phase;
    int   target_len;
    int   eff;
    mix_t mix;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_window_len = 7'd64;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // partial window at the reset length, then shorten it below the fill
    send_item(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0));
    write_window_len(7'd2);
    send_item(mk(100, -100, 200, 0, -300, 5, 0, 0));

    write_window_len(7'd1);
    send_item(mk(1, 0, 2, 0, 3, 0, 4, 0));
    send_item(mk(-32768, -32768, 32767, 32767, 1000, -1000, 0, 1));
    send_item(mk(5, -5, -5, 5, 5, 5, -5, -5));
    send_item(mk(0, 3, 32767, 0, 0, 32767, 3, 0));
    send_item(mk(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555,
                 16'sh5555, 16'sh5555, 16'shAAAA, 16'shAAAA));
    send_item(mk(0, 0, 0, 0, 0, 0, 0, 0));

    write_window_len(7'd0);
    send_item(mk(-1, -1, 0, 0, 1, 1, -32768, 32767));
    send_item(mk(32767, -32768, -2, 2, 0, -32768, 7, 7));

    write_window_len(7'd3);
    send_item(mk(10, 10, -20, 0, 30, -30, 0, 40));
    send_item(mk(-10, 0, 20, 20, -30, 0, 40, -40));
    send_item(mk(0, -10, 0, -20, 0, 30, -40, 0));

    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase == 0) begin
        target_len = 64;
      end else if (phase == 1) begin
        target_len = 127;
      end else begin
        case ($urandom_range(0, 7))
          0: target_len = 0;
          1: target_len = $urandom_range(9, 20);
          default: target_len = $urandom_range(1, 8);
        endcase
      end
      write_window_len(CFG_W'(target_len));
      eff = (target_len == 0) ? 1 : (target_len > WINDOW_CAP ? WINDOW_CAP : target_len);
      repeat (eff >= 32 ? 1 : $urandom_range(1, 4)) begin
        if (items_sent < ITEM_GOAL) begin
          mix = mix_t'($urandom_range(0, 3));
          foreach (lane_shift[c]) lane_shift[c] = $urandom_range(0, 12);
          repeat (eff) send_item(rand_item(mix));
          if ($urandom_range(0, 5) == 0) wait_drain();
        end
      end
      // leave a window open now and then so the next length lands mid-window
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_item(rand_item(MIX_FULL));
      phase++;
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests, %0d windows, %0d rows checked, %0d length writes",
             items_sent, board.windows_closed, board.rows_checked, cfg_writes);
    $display("lengths 0 to 127 incl. saturation, ties and mid-window shortening; %0d errors",
             board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
